[src/dtfdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dtfdm_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_FAST_HZ = 2'd0;
    localparam logic [1:0] REG_SLOW_HZ = 2'd1;
    localparam logic [1:0] REG_TPS     = 2'd2;

    localparam logic [31:0] FAST_MIN_WIDTH = 32'd15;
    localparam logic [31:0] LOW_FREQ_Q8    = 32'd12800;
    localparam logic [31:0] US_PER_S       = 32'd1000000;
    localparam logic [31:0] ALL_ONES       = 32'hffffffff;
    localparam logic [31:0] FAST_MASK      = 32'h0000ffff;

    // One entry of the per-channel state memory.
    typedef struct packed {
        logic        phase;
        logic        fall_valid;
        logic [31:0] rise_stamp;
        logic [31:0] fall_stamp;
        logic [31:0] width_count;
        logic [31:0] period_count;
        logic [31:0] total_pulses;
        logic [31:0] second_pulses;
        logic [31:0] window_start;
        logic [31:0] window_base;
    } entry_t;

endpackage
`default_nettype wire

[src/dtfdm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64-bit dividend over
// 32-bit divisor. The quotient saturates to 32 bits.
module dtfdm_div
    import dtfdm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;

    // Shift in the next dividend bit and try one subtraction.
    always_comb
    begin
        rem_shift = {rem_reg[31:0], quo_reg[63]};
        rem_sub   = rem_shift - {1'b0, divisor};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign quotient = (quo_reg[63:32] != 32'd0) ? ALL_ONES : quo_reg[31:0];

endmodule
`default_nettype wire

[src/dual_timebase_frequency_duty_meter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Dual time-base frequency and duty meter.
// Input stream (s_axis): one command per transfer: edge, query or clear for
// one channel. Output stream (m_axis): one result per query, nothing for
// edge and clear. Configuration channel (cfg_*): clock rates and the ticks
// per second, to be written by the user only while the block is idle; the
// block itself does not enforce this. Per-channel state for both time bases
// lives in one synchronous memory of 2*NUM_CHANNELS entries with a registered
// read; commands are taken one at a time, read-modify-write. A query runs up
// to seven divisions through one shared bit-serial divider (fast width,
// frequency and duty, then slow width, frequency and duty, then seconds).
// Reset clears the entries with a sweep over all 2*NUM_CHANNELS entries while
// no command is taken, and loads the register defaults. A stalled result
// waits in the output register; the next command is taken once it is
// delivered.
module dual_timebase_frequency_duty_meter_core
    import dtfdm_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // opcode[1:0], channel[3:2], source[4], capture_value[36:5], now_tick[68:37]
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // valid_measure[0], mode_used[1], frequency_q8[33:2], pulse_width_us[65:34],
    // duty_percent[72:66], pulse_count[104:73], pulses_last_second[136:105],
    // seconds_now[168:137]
    output logic [175:0]     m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int NENT = 2 * NUM_CHANNELS;
    localparam int AW   = $clog2(NENT);

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_READ  = 10'b0000000100,
        S_EDGE  = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_NEXT  = 10'b0000100000,
        S_RDS   = 10'b0001000000,
        S_SLOW  = 10'b0010000000,
        S_SEC   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg;
    entry_t mem [NENT];
    entry_t rd_reg;
    logic [AW-1:0] init_reg;

    logic [26:0] fast_hz_reg;
    logic [19:0] slow_hz_reg;
    logic [19:0] tps_reg;

    logic [1:0]  op_reg;
    logic [1:0]  ch_reg;
    logic        src_reg;
    logic [31:0] cap_reg;
    logic [31:0] now_reg;
    logic        fast_reg;   // which base is being measured
    logic [1:0]  step_reg;   // division within an attempt
    logic [31:0] wus_reg, freq_reg;
    logic [175:0] out_reg;
    logic        out_valid_reg;

    logic        wr_en;
    logic [AW-1:0] wr_addr;
    entry_t      wr_data;
    logic [AW-1:0] rd_addr;
    logic        sel_fast;

    logic        div_start, div_done;
    logic [63:0] div_a;
    logic [31:0] div_b, div_q;

    logic        inrange;
    logic [31:0] clk_eff, tps_eff, mask, t_val, tot_inc;
    logic        bad;
    entry_t      edge_next;

    dtfdm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign inrange = {30'd0, ch_reg} < NUM_CHANNELS;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign tps_eff = (tps_reg == 20'd0) ? 32'd1 : {12'd0, tps_reg};

    // Effective clock and failure test of the current attempt.
    always_comb
    begin
        if (fast_reg)
            clk_eff = (fast_hz_reg == 27'd0) ? 32'd1 : {5'd0, fast_hz_reg};
        else
            clk_eff = (slow_hz_reg == 20'd0) ? 32'd1 : {12'd0, slow_hz_reg};
        if (fast_reg)
            bad = rd_reg.width_count < FAST_MIN_WIDTH;
        else
            bad = (rd_reg.width_count == 32'd0) || (rd_reg.width_count > clk_eff);
        bad = bad || (rd_reg.period_count == 32'd0);
    end

    // Edge update of the entry just read.
    always_comb
    begin
        mask      = src_reg ? FAST_MASK : ALL_ONES;
        t_val     = cap_reg & mask;
        edge_next = rd_reg;
        tot_inc   = rd_reg.total_pulses + 32'd1;
        if (tot_inc == ALL_ONES)
            tot_inc = 32'd0;
        if (!rd_reg.phase)
        begin
            if (rd_reg.fall_valid)
            begin
                edge_next.width_count  = (rd_reg.fall_stamp - rd_reg.rise_stamp) & mask;
                edge_next.period_count = (t_val - rd_reg.rise_stamp) & mask;
                edge_next.total_pulses = tot_inc;
                if ((now_reg - rd_reg.window_start) >= tps_eff)
                begin
                    edge_next.second_pulses = tot_inc - rd_reg.window_base;
                    edge_next.window_start  = now_reg;
                    edge_next.window_base   = tot_inc;
                end
                edge_next.fall_valid = 1'b0;
            end
            edge_next.rise_stamp = t_val;
            edge_next.phase      = 1'b1;
        end
        else
        begin
            edge_next.fall_stamp = t_val;
            edge_next.fall_valid = 1'b1;
            edge_next.phase      = 1'b0;
        end
    end

    // Divider operands for each step.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                div_a = {32'd0, rd_reg.width_count} * {32'd0, US_PER_S};
                div_b = clk_eff;
            end
            2'd1:
            begin
                div_a = {24'd0, clk_eff, 8'd0};
                div_b = rd_reg.period_count;
            end
            2'd2:
            begin
                div_a = {32'd0, rd_reg.width_count} * 64'd100;
                div_b = rd_reg.period_count;
            end
            default:
            begin
                div_a = {32'd0, now_reg};
                div_b = tps_eff;
            end
        endcase
    end

    // Memory port addresses and write data. An edge works on the base of its
    // source; a query reads the fast entry first and the slow entry in S_SLOW.
    always_comb
    begin
        sel_fast = fast_reg;
        if (op_reg == OP_EDGE)
            sel_fast = src_reg;
        else if (state_reg == S_READ && op_reg == OP_QUERY)
            sel_fast = 1'b1;
        else if (state_reg == S_SLOW)
            sel_fast = 1'b0;
        rd_addr = sel_fast ? AW'(NUM_CHANNELS + {30'd0, ch_reg})
                           : AW'({30'd0, ch_reg});
        wr_en   = 1'b0;
        wr_addr = rd_addr;
        wr_data = rd_reg;
        if (state_reg == S_INIT)
        begin
            wr_en   = 1'b1;
            wr_addr = init_reg;
            wr_data = '0;
        end
        else if (state_reg == S_EDGE)
        begin
            wr_en   = 1'b1;
            wr_data = edge_next;
        end
        else if (state_reg == S_READ && op_reg == OP_CLEAR && inrange)
        begin
            wr_en   = 1'b1;
            wr_data = '0;
            wr_data.window_start = now_reg;
        end
        else if (state_reg == S_DIV && div_done && step_reg == 2'd2)
        begin
            wr_en   = 1'b1;
            wr_data.width_count  = 32'd0;
            wr_data.period_count = 32'd0;
        end
    end

    // State memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    assign div_start = (state_reg == S_RDS) || (state_reg == S_NEXT) ||
                       (state_reg == S_SEC);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_hz_reg <= 27'd1000000;
            slow_hz_reg <= 20'd1000;
            tps_reg     <= 20'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FAST_HZ: fast_hz_reg <= cfg_data[26:0];
                REG_SLOW_HZ: slow_hz_reg <= cfg_data[19:0];
                REG_TPS:     tps_reg     <= cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Command sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            init_reg      <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_EDGE;
            ch_reg        <= '0;
            src_reg       <= 1'b0;
            cap_reg       <= '0;
            now_reg       <= '0;
            fast_reg      <= 1'b0;
            step_reg      <= '0;
            wus_reg       <= '0;
            freq_reg      <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + AW'(1);
                    if (32'(init_reg) == NENT - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg   <= s_axis_tdata[1:0];
                        ch_reg   <= s_axis_tdata[3:2];
                        src_reg  <= s_axis_tdata[4];
                        cap_reg  <= s_axis_tdata[36:5];
                        now_reg  <= s_axis_tdata[68:37];
                        fast_reg <= 1'b0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // Clear writes both bases: slow now, fast on the next pass.
                    if (op_reg == OP_EDGE)
                        state_reg <= inrange ? S_EDGE : S_IDLE;
                    else if (op_reg == OP_CLEAR)
                    begin
                        if (!inrange || fast_reg)
                            state_reg <= S_IDLE;
                        fast_reg <= 1'b1;
                    end
                    else if (op_reg == OP_QUERY)
                    begin
                        out_reg  <= '0;
                        fast_reg <= 1'b1;
                        step_reg <= inrange ? 2'd0 : 2'd3;
                        state_reg <= inrange ? S_RDS : S_SEC;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_EDGE:
                    state_reg <= S_IDLE;
                S_RDS:
                begin
                    // rd_reg now holds the entry of the base under test.
                    if (bad)
                    begin
                        out_reg[1]      <= fast_reg;
                        out_reg[0]      <= 1'b0;
                        out_reg[33:2]   <= 32'd0;
                        out_reg[65:34]  <= fast_reg ? 32'd0 : US_PER_S;
                        out_reg[72:66]  <= fast_reg ? 7'd0 : 7'd100;
                        out_reg[136:73] <= '0;
                        step_reg  <= 2'd3;
                        state_reg <= fast_reg ? S_SLOW : S_SEC;
                    end
                    else
                        state_reg <= S_DIV;
                end
                S_NEXT:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    if (div_done)
                    begin
                        if (step_reg == 2'd0)
                        begin
                            wus_reg  <= div_q;
                            step_reg <= 2'd1;
                            state_reg <= S_NEXT;
                        end
                        else if (step_reg == 2'd1)
                        begin
                            freq_reg <= div_q;
                            step_reg <= 2'd2;
                            state_reg <= S_NEXT;
                        end
                        else if (step_reg == 2'd2)
                        begin
                            out_reg[0]       <= 1'b1;
                            out_reg[1]       <= fast_reg;
                            out_reg[33:2]    <= freq_reg;
                            out_reg[65:34]   <= wus_reg;
                            out_reg[72:66]   <= (div_q > 32'd100) ? 7'd100 : div_q[6:0];
                            out_reg[104:73]  <= rd_reg.total_pulses;
                            out_reg[136:105] <= rd_reg.second_pulses;
                            step_reg         <= 2'd3;
                            if (fast_reg && freq_reg < LOW_FREQ_Q8)
                                state_reg <= S_SLOW;
                            else
                                state_reg <= S_SEC;
                        end
                        else
                        begin
                            out_reg[168:137] <= div_q;
                            out_valid_reg    <= 1'b1;
                            state_reg        <= S_OUT;
                        end
                    end
                end
                S_SLOW:
                begin
                    // Read the slow entry; result lands in rd_reg next cycle.
                    fast_reg  <= 1'b0;
                    step_reg  <= 2'd0;
                    state_reg <= S_RDS;
                end
                S_SEC:
                begin
                    step_reg  <= 2'd3;
                    state_reg <= S_DIV;
                end
                S_OUT:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/dtfdm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module dtfdm_checker
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [175:0] m_axis_tdata
);

    // A result waits until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // Duty never exceeds one hundred.
    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[72:66] <= 7'd100)
        else $error("duty above 100");

    // No command is taken while a result is pending.
    a_block: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("command taken with result pending");

    // A failed measurement reports zero frequency.
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[33:2] == 32'd0)
        else $error("failed result with frequency");

endmodule

bind dual_timebase_frequency_duty_meter_core dtfdm_checker u_dtfdm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[tb/sv/tb_dual_timebase_frequency_duty_meter_core.sv]
`timescale 1ns / 1ps
module tb_dual_timebase_frequency_duty_meter_core;
    import dtfdm_pkg::*;

    localparam int NCH = 4;
    localparam int NENT = 2 * NCH;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic SRC_SLOW = 1'b0;
    localparam logic SRC_FAST = 1'b1;

    typedef struct packed {
        logic        ok;
        logic        mode;
        logic [31:0] freq;
        logic [31:0] width_us;
        logic [6:0]  duty;
        logic [31:0] count;
        logic [31:0] per_second;
        logic [31:0] seconds;
    } meas_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [175:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // Shadow of the meter state and registers.
    logic [31:0] fast_hz, slow_hz, tps;
    logic        phase_q[NENT];
    logic        fall_held[NENT];
    logic [31:0] rise_t[NENT], fall_t[NENT], width_cnt[NENT], period_cnt[NENT];
    logic [31:0] total_cnt[NENT], second_cnt[NENT], win_start[NENT], win_base[NENT];

    meas_t pending_results[$];
    int    mismatches;
    bit    quiet;
    int    stall_left;
    logic [31:0] now_q;

    dual_timebase_frequency_duty_meter_core #(.NUM_CHANNELS(NCH)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'hffffffff) ? ALL_ONES : v[31:0];
    endfunction

    function automatic void clear_entry(input int e, input logic [31:0] now);
        phase_q[e] = 0; fall_held[e] = 0; rise_t[e] = 0; fall_t[e] = 0;
        width_cnt[e] = 0; period_cnt[e] = 0; total_cnt[e] = 0; second_cnt[e] = 0;
        win_start[e] = now; win_base[e] = 0;
    endfunction

    function automatic void apply_edge(input int e, input logic fast,
                                       input logic [31:0] cap, input logic [31:0] now);
        logic [31:0] mask, t, lim;
        mask = fast ? FAST_MASK : ALL_ONES;
        t = cap & mask;
        lim = (tps == 0) ? 32'd1 : tps;
        if (!phase_q[e]) begin
            // A rising edge after a held falling edge closes one pulse.
            if (fall_held[e]) begin
                width_cnt[e] = (fall_t[e] - rise_t[e]) & mask;
                period_cnt[e] = (t - rise_t[e]) & mask;
                total_cnt[e] = total_cnt[e] + 1;
                if (total_cnt[e] == ALL_ONES)
                    total_cnt[e] = 0;
                if (now - win_start[e] >= lim) begin
                    second_cnt[e] = total_cnt[e] - win_base[e];
                    win_start[e] = now;
                    win_base[e] = total_cnt[e];
                end
                fall_held[e] = 0;
            end
            rise_t[e] = t;
            phase_q[e] = 1;
        end
        else begin
            fall_t[e] = t;
            fall_held[e] = 1;
            phase_q[e] = 0;
        end
    endfunction

    function automatic meas_t measure_base(input int e, input logic fast);
        meas_t m;
        logic [63:0] clk64, w, p, q;
        clk64 = fast ? {32'd0, fast_hz} : {32'd0, slow_hz};
        if (clk64 == 0)
            clk64 = 1;
        w = {32'd0, width_cnt[e]};
        p = {32'd0, period_cnt[e]};
        m = '0;
        m.mode = fast;
        if ((fast ? (w < 15) : (w == 0 || w > clk64)) || p == 0) begin
            m.duty = fast ? 7'd0 : 7'd100;
            m.width_us = fast ? 32'd0 : US_PER_S;
            return m;
        end
        m.ok = 1;
        m.width_us = sat32(w * 64'd1000000 / clk64);
        m.freq = sat32(clk64 * 64'd256 / p);
        q = w * 64'd100 / p;
        m.duty = (q > 100) ? 7'd100 : q[6:0];
        m.count = total_cnt[e];
        m.per_second = second_cnt[e];
        width_cnt[e] = 0;
        period_cnt[e] = 0;
        return m;
    endfunction

    // Updates the shadow state for one accepted command, queues any result.
    function automatic void predict_command(input logic [1:0] op, input logic [1:0] ch,
                                            input logic src, input logic [31:0] cap,
                                            input logic [31:0] now);
        meas_t m;
        case (op)
            OP_EDGE:  apply_edge(src * NCH + ch, src, cap, now);
            OP_CLEAR:
            begin
                clear_entry(ch, now);
                clear_entry(NCH + ch, now);
            end
            OP_QUERY:
            begin
                m = measure_base(NCH + ch, 1'b1);
                if (!m.ok || m.freq < LOW_FREQ_Q8)
                    m = measure_base(ch, 1'b0);
                m.seconds = now / ((tps == 0) ? 32'd1 : tps);
                pending_results.push_back(m);
            end
            default: ;
        endcase
    endfunction

    // Result checker.
    always @(posedge clk) begin
        meas_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok = m_axis_tdata[0];
            got.mode = m_axis_tdata[1];
            got.freq = m_axis_tdata[33:2];
            got.width_us = m_axis_tdata[65:34];
            got.duty = m_axis_tdata[72:66];
            got.count = m_axis_tdata[104:73];
            got.per_second = m_axis_tdata[136:105];
            got.seconds = m_axis_tdata[168:137];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %p", got);
            end
            else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok || got.mode !== want.mode || got.freq !== want.freq ||
                    got.width_us !== want.width_us || got.duty !== want.duty ||
                    got.count !== want.count || got.per_second !== want.per_second ||
                    got.seconds !== want.seconds) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // Result side back-pressure in random bursts.
    always @(posedge clk) begin
        if (quiet) begin
            m_axis_tready <= 1;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 0;
        end
        else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_axis_tready <= 0;
        end
        else begin
            m_axis_tready <= 1;
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [1:0] ch, input logic src,
                            input logic [31:0] cap, input logic [31:0] now);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {3'b000, now, cap, src, ch, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_command(op, ch, src, cap, now);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_FAST_HZ: fast_hz = val & 32'h07ffffff;
            REG_SLOW_HZ: slow_hz = val & 32'h000fffff;
            REG_TPS:     tps = val & 32'h000fffff;
            default: ;
        endcase
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic set_rates(input logic [31:0] f, input logic [31:0] s, input logic [31:0] t);
        wait_idle();
        write_reg(REG_FAST_HZ, f);
        write_reg(REG_SLOW_HZ, s);
        write_reg(REG_TPS, t);
    endtask

    // Rise, fall, rise on one channel and base.
    task automatic pulse(input logic [1:0] ch, input logic src, input logic [31:0] r,
                         input logic [31:0] f, input logic [31:0] r2, input logic [31:0] now);
        send_cmd(OP_EDGE, ch, src, r, now);
        send_cmd(OP_EDGE, ch, src, f, now);
        send_cmd(OP_EDGE, ch, src, r2, now);
    endtask

    task automatic test_directed();
        // Query with nothing measured, then a clean fast pulse.
        send_cmd(OP_QUERY, 2'd0, SRC_SLOW, 32'd0, 32'd0);
        pulse(2'd1, SRC_FAST, 32'd100, 32'd150, 32'd1100, 32'd10);
        send_cmd(OP_QUERY, 2'd1, SRC_SLOW, 32'd0, 32'hffffffff);
        // Fast width too short; the slow base answers instead, and fails on zero width.
        pulse(2'd2, SRC_FAST, 32'd0, 32'd14, 32'd500, 32'd20);
        pulse(2'd2, SRC_SLOW, 32'd5, 32'd5, 32'd10, 32'd20);
        send_cmd(OP_QUERY, 2'd2, SRC_FAST, 32'd0, 32'd1500);
        // Wrap of the 16-bit base with upper capture bits set.
        pulse(2'd3, SRC_FAST, 32'hfffffff0, 32'hffff0010, 32'h12340100, 32'd3000);
        send_cmd(OP_QUERY, 2'd3, SRC_FAST, 32'hffffffff, 32'd3000);
        // Fast under 50 Hz falls back to a valid slow pulse.
        pulse(2'd0, SRC_FAST, 32'd0, 32'd100, 32'd30000, 32'd4000);
        pulse(2'd0, SRC_SLOW, 32'hffffff00, 32'd50, 32'd400, 32'd4000);
        send_cmd(OP_QUERY, 2'd0, SRC_FAST, 32'd0, 32'd4001);
        // Zero period and width over period.
        pulse(2'd1, SRC_FAST, 32'd10, 32'd40, 32'h0001000a, 32'd5000);
        send_cmd(OP_QUERY, 2'd1, SRC_FAST, 32'd0, 32'd5000);
        pulse(2'd1, SRC_FAST, 32'd100, 32'd5000, 32'd200, 32'd5000);
        send_cmd(OP_QUERY, 2'd1, SRC_FAST, 32'd0, 32'd5000);
        // Unused opcode and a clear.
        send_cmd(OP_NOP, 2'd3, SRC_FAST, 32'hffffffff, 32'hffffffff);
        send_cmd(OP_CLEAR, 2'd3, SRC_SLOW, 32'd0, 32'd7000);
        send_cmd(OP_QUERY, 2'd3, SRC_SLOW, 32'd0, 32'd7000);
    endtask

    // Well-formed pulse trains with queries, mixed with random commands.
    task automatic test_random(input int n);
        int done, k;
        logic [1:0] ch;
        logic src;
        logic [31:0] t, maxi;
        done = 0;
        while (done < n) begin
            if ($urandom_range(0, 9) < 8) begin
                ch = 2'($urandom_range(0, 3));
                src = 1'($urandom_range(0, 1));
                t = $urandom;
                maxi = ($urandom_range(0, 3) == 0) ? 32'd70000 : 32'd3000;
                k = $urandom_range(1, 4);
                repeat (2 * k + 1) begin
                    now_q = now_q + $urandom_range(0, 800);
                    send_cmd(OP_EDGE, ch, src, t, now_q);
                    t = t + $urandom_range(1, maxi);
                    done++;
                end
                if ($urandom_range(0, 9) < 8) begin
                    send_cmd(OP_QUERY, ch, 1'($urandom_range(0, 1)), $urandom, now_q);
                    done++;
                end
            end
            else begin
                if ($urandom_range(0, 7) == 0)
                    now_q = $urandom;
                send_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), $urandom, $urandom);
                done++;
            end
        end
    endtask

    task automatic test_config_sweep();
        set_rates(32'd1, 32'd1, 32'd1);
        test_random(200);
        set_rates(32'd100000000, 32'd1000000, 32'd1000000);
        test_random(200);
        set_rates(32'd0, 32'd0, 32'd0);
        test_random(150);
        set_rates(32'hffffffff, 32'hffffffff, 32'hffffffff);
        test_random(150);
        set_rates($urandom_range(1, 100000000), $urandom_range(1, 1000000),
                  $urandom_range(1, 1000000));
        test_random(200);
        set_rates(32'd1000000, 32'd1000, 32'd1000);
        quiet = 1;
        test_random(150);
    endtask

    initial begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        m_axis_tready = 0;
        cfg_valid = 0;
        cfg_index = REG_FAST_HZ;
        cfg_data = '0;
        mismatches = 0;
        quiet = 0;
        stall_left = 0;
        now_q = 0;
        fast_hz = 32'd1000000;
        slow_hz = 32'd1000;
        tps = 32'd1000;
        for (int e = 0; e < NENT; e++)
            clear_entry(e, 32'd0);
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        test_directed();
        test_random(500);
        test_config_sweep();

        wait_idle();
        repeat (500) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #60ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
